### sv/pfpi_pkg.sv
package pfpi_pkg;

    localparam int NUM_CELLS_DEF = 256;

    localparam int SAMPLE_W = 32;
    localparam int COEF_W   = 32;
    localparam int CELL_W   = 8;
    localparam int FIELD_W  = 48;
    localparam int ACC_W    = 56;
    localparam int SUM_W    = 64;

    // APB: one 32-bit register per 4-byte word, index in paddr[APB_AW-1:2]
    localparam int APB_DW = 32;
    localparam int APB_AW = 3;
    localparam logic [APB_AW-3:0] REG_FIELD_COEF = '0;

    localparam logic signed [COEF_W-1:0] COEF_RESET = 32'sd65536;

    localparam int QUEUE_DEPTH = 4;

    typedef enum logic [1:0] {
        KIND_ACC     = 2'd0,
        KIND_ACC_EOC = 2'd1,
        KIND_READ    = 2'd2
    } kind_t;

    typedef struct packed {
        kind_t                      kind;
        logic signed [SAMPLE_W-1:0] sample;
        logic [CELL_W-1:0]          cell_id;
    } entry_t;

    typedef struct packed {
        logic   valid;
        entry_t entry;
    } queue_head_t;

endpackage

### sv/pfpi_if.sv
interface pfpi_in_if import pfpi_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic                       op;
    logic signed [SAMPLE_W-1:0] sample_value;
    logic                       end_of_cell;
    logic [CELL_W-1:0]          cell_index;

    modport source (
        output valid, op, sample_value, end_of_cell, cell_index,
        input  ready
    );
    modport sink (
        input  valid, op, sample_value, end_of_cell, cell_index,
        output ready
    );
endinterface

interface pfpi_out_if import pfpi_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [FIELD_W-1:0] field_value;
    logic                      field_ready;
    logic                      saturated;

    modport source (
        output valid, field_value, field_ready, saturated,
        input  ready
    );
    modport sink (
        input  valid, field_value, field_ready, saturated,
        output ready
    );
endinterface

### sv/pfpi_ram.sv
module pfpi_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### sv/pfpi_front.sv
module pfpi_front import pfpi_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    pfpi_in_if.sink     item,
    output queue_head_t head,
    input  logic        pop
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = PTR_W + 1;

    entry_t           queue_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             push;
    entry_t           entry_in;

    assign item.ready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign push       = item.valid && item.ready;

    // classify: reads ignore the flag, samples split on end of cell
    always_comb
    begin
        entry_in.sample  = item.sample_value;
        entry_in.cell_id = item.cell_index;
        if (item.op)
        begin
            entry_in.kind = KIND_READ;
        end
        else if (item.end_of_cell)
        begin
            entry_in.kind = KIND_ACC_EOC;
        end
        else
        begin
            entry_in.kind = KIND_ACC;
        end
    end

    assign head.valid = (count_reg != '0);
    assign head.entry = queue_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_reg[wr_ptr_reg] <= entry_in;
        end
    end

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head.valid)
        else $error("queue popped while empty");

    a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue count missed a push");

endmodule

### sv/pfpi_back.sv
module pfpi_back import pfpi_pkg::*; #(
    parameter int NUM_CELLS = NUM_CELLS_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  queue_head_t              head,
    output logic                     pop,
    input  logic signed [COEF_W-1:0] coef,
    pfpi_out_if.source               result
);

    localparam int L       = $clog2(NUM_CELLS);
    localparam int SH      = L + 17;
    localparam int OPER_W  = 33;
    localparam int PROD_W  = 2 * OPER_W;
    localparam int WIDE_W  = 128;
    localparam int S_W     = 96;

    localparam logic signed [OPER_W-1:0] N_OPER  = OPER_W'(NUM_CELLS);
    localparam logic signed [OPER_W-1:0] NEG_2N  = -(N_OPER <<< 1);
    localparam logic signed [OPER_W-1:0] ONE     = OPER_W'(1);
    localparam logic signed [OPER_W-1:0] TWO     = OPER_W'(2);
    localparam logic signed [WIDE_W-1:0] RND     = WIDE_W'(1) << (SH - 1);
    localparam logic [L-1:0]             LAST_CELL = L'(NUM_CELLS - 1);

    localparam logic signed [ACC_W-1:0]   ACC_MAX   = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0]   ACC_MIN   = {1'b1, {(ACC_W-1){1'b0}}};
    localparam logic signed [SUM_W-1:0]   SUM_MAX   = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0]   SUM_MIN   = {1'b1, {(SUM_W-1){1'b0}}};
    localparam logic signed [FIELD_W-1:0] FIELD_MAX = {1'b0, {(FIELD_W-1){1'b1}}};
    localparam logic signed [FIELD_W-1:0] FIELD_MIN = {1'b1, {(FIELD_W-1){1'b0}}};

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_CLOSE = 2'd1;
    localparam logic [1:0] ST_MAC   = 2'd2;
    localparam logic [1:0] ST_OUT   = 2'd3;

    localparam logic [3:0] STEP_TOT_LO  = 4'd0;
    localparam logic [3:0] STEP_TOT_HI  = 4'd1;
    localparam logic [3:0] STEP_PRE_LO  = 4'd2;
    localparam logic [3:0] STEP_PRE_HI  = 4'd3;
    localparam logic [3:0] STEP_PSUM_LO = 4'd4;
    localparam logic [3:0] STEP_PSUM_HI = 4'd5;
    localparam logic [3:0] STEP_COEF_0  = 4'd6;
    localparam logic [3:0] STEP_COEF_1  = 4'd7;
    localparam logic [3:0] STEP_COEF_2  = 4'd8;

    localparam logic [1:0] SHIFT_0  = 2'd0;
    localparam logic [1:0] SHIFT_32 = 2'd1;
    localparam logic [1:0] SHIFT_64 = 2'd2;

    function automatic logic signed [ACC_W-1:0] sat_acc(
        input logic signed [ACC_W-1:0]    a,
        input logic signed [SAMPLE_W-1:0] b
    );
        logic [ACC_W:0] s;
        s = {a[ACC_W-1], a} + {{(ACC_W+1-SAMPLE_W){b[SAMPLE_W-1]}}, b};
        if (s[ACC_W] != s[ACC_W-1])
        begin
            sat_acc = s[ACC_W] ? ACC_MIN : ACC_MAX;
        end
        else
        begin
            sat_acc = s[ACC_W-1:0];
        end
    endfunction

    function automatic logic signed [SUM_W-1:0] sat_sum(
        input logic signed [SUM_W-1:0] a,
        input logic signed [SUM_W-1:0] b
    );
        logic [SUM_W:0] s;
        s = {a[SUM_W-1], a} + {b[SUM_W-1], b};
        if (s[SUM_W] != s[SUM_W-1])
        begin
            sat_sum = s[SUM_W] ? SUM_MIN : SUM_MAX;
        end
        else
        begin
            sat_sum = s[SUM_W-1:0];
        end
    endfunction

    // control and model state
    logic [1:0]               state_reg,      state_next;
    logic [3:0]               step_reg,       step_next;
    logic signed [ACC_W-1:0]  acc_reg,        acc_next;
    logic signed [SUM_W-1:0]  total_reg,      total_next;
    logic signed [SUM_W-1:0]  psum_reg,       psum_next;
    logic [L-1:0]             counter_reg,    counter_next;
    logic                     frame_done_reg, frame_done_next;
    logic                     live_reg,       live_next;
    logic                     out_valid_reg,  out_valid_next;

    // datapath
    logic signed [OPER_W-1:0] factor_reg,     factor_next;
    logic signed [WIDE_W-1:0] wide_reg,       wide_next;
    logic [S_W-1:0]           s_reg;
    logic signed [FIELD_W-1:0] field_reg;
    logic                     field_ready_reg;
    logic                     sat_reg;

    logic                     rd_issue;
    logic                     load_out;
    logic [CELL_W+L-1:0]      idx_ext;
    logic [L-1:0]             read_idx;
    logic [SUM_W-1:0]         prefix;

    logic signed [OPER_W-1:0] oper_a;
    logic signed [OPER_W-1:0] oper_b;
    logic signed [PROD_W-1:0] prod;
    logic signed [WIDE_W-1:0] prod_ext;
    logic signed [WIDE_W-1:0] addend;
    logic signed [WIDE_W-1:0] base;
    logic [1:0]               shift_sel;

    logic signed [WIDE_W-1:0] shifted;
    logic                     in_range;
    logic signed [FIELD_W-1:0] field_sat;

    pfpi_ram #(
        .WIDTH (SUM_W),
        .DEPTH (NUM_CELLS)
    ) u_prefix_ram (
        .clk   (clk),
        .we    (state_reg == ST_CLOSE),
        .waddr (counter_reg),
        .wdata (total_reg),
        .re    (rd_issue),
        .raddr (read_idx),
        .rdata (prefix)
    );

    // cell index wraps modulo the cell count
    assign idx_ext     = {{L{1'b0}}, head.entry.cell_id};
    assign read_idx    = idx_ext[L-1:0];
    assign factor_next = $signed({{(OPER_W-L-1){1'b0}}, read_idx, 1'b0}) - N_OPER + ONE;

    // shared multiply-accumulate: S first, then S * coef on top of the rounding bias
    always_comb
    begin
        oper_a    = '0;
        oper_b    = '0;
        shift_sel = SHIFT_0;
        base      = wide_reg;
        case (step_reg)
            STEP_TOT_LO:
            begin
                oper_a = {1'b0, total_reg[31:0]};
                oper_b = factor_reg;
                base   = '0;
            end
            STEP_TOT_HI:
            begin
                oper_a    = {total_reg[SUM_W-1], total_reg[SUM_W-1:32]};
                oper_b    = factor_reg;
                shift_sel = SHIFT_32;
            end
            STEP_PRE_LO:
            begin
                oper_a = {1'b0, prefix[31:0]};
                oper_b = NEG_2N;
            end
            STEP_PRE_HI:
            begin
                oper_a    = {prefix[SUM_W-1], prefix[SUM_W-1:32]};
                oper_b    = NEG_2N;
                shift_sel = SHIFT_32;
            end
            STEP_PSUM_LO:
            begin
                oper_a = {1'b0, psum_reg[31:0]};
                oper_b = TWO;
            end
            STEP_PSUM_HI:
            begin
                oper_a    = {psum_reg[SUM_W-1], psum_reg[SUM_W-1:32]};
                oper_b    = TWO;
                shift_sel = SHIFT_32;
            end
            STEP_COEF_0:
            begin
                oper_a = {1'b0, wide_reg[31:0]};
                oper_b = {coef[COEF_W-1], coef};
                base   = RND;
            end
            STEP_COEF_1:
            begin
                oper_a    = {1'b0, s_reg[63:32]};
                oper_b    = {coef[COEF_W-1], coef};
                shift_sel = SHIFT_32;
            end
            STEP_COEF_2:
            begin
                oper_a    = {s_reg[S_W-1], s_reg[S_W-1:64]};
                oper_b    = {coef[COEF_W-1], coef};
                shift_sel = SHIFT_64;
            end
            default:
            begin
                oper_a = '0;
            end
        endcase
    end

    assign prod     = oper_a * oper_b;
    assign prod_ext = {{(WIDE_W-PROD_W){prod[PROD_W-1]}}, prod};

    always_comb
    begin
        case (shift_sel)
            SHIFT_32: addend = prod_ext <<< 32;
            SHIFT_64: addend = prod_ext <<< 64;
            default:  addend = prod_ext;
        endcase
    end

    assign wide_next = base + addend;

    // final scale, then clip to the 48-bit output range
    assign shifted   = wide_reg >>> SH;
    assign in_range  = (&shifted[WIDE_W-1:FIELD_W-1]) || !(|shifted[WIDE_W-1:FIELD_W-1]);
    assign field_sat = in_range ? shifted[FIELD_W-1:0]
                                : (shifted[WIDE_W-1] ? FIELD_MIN : FIELD_MAX);

    always_comb
    begin
        state_next      = state_reg;
        step_next       = step_reg;
        acc_next        = acc_reg;
        total_next      = total_reg;
        psum_next       = psum_reg;
        counter_next    = counter_reg;
        frame_done_next = frame_done_reg;
        live_next       = live_reg;
        out_valid_next  = out_valid_reg && !result.ready;
        pop             = 1'b0;
        rd_issue        = 1'b0;
        load_out        = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (head.valid)
                begin
                    pop = 1'b1;
                    unique case (head.entry.kind) inside
                        KIND_ACC, KIND_ACC_EOC:
                        begin
                            // first sample after a full frame opens a new one
                            if (frame_done_reg)
                            begin
                                total_next      = '0;
                                psum_next       = '0;
                                frame_done_next = 1'b0;
                            end
                            acc_next = sat_acc(acc_reg, head.entry.sample);
                            if (head.entry.kind == KIND_ACC_EOC)
                            begin
                                state_next = ST_CLOSE;
                            end
                        end
                        KIND_READ:
                        begin
                            live_next = frame_done_reg;
                            if (frame_done_reg)
                            begin
                                rd_issue   = 1'b1;
                                step_next  = STEP_TOT_LO;
                                state_next = ST_MAC;
                            end
                            else
                            begin
                                state_next = ST_OUT;
                            end
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_CLOSE:
            begin
                psum_next  = sat_sum(psum_reg, total_reg);
                total_next = sat_sum(total_reg,
                                     {{(SUM_W-ACC_W){acc_reg[ACC_W-1]}}, acc_reg});
                acc_next   = '0;
                if (counter_reg == LAST_CELL)
                begin
                    counter_next    = '0;
                    frame_done_next = 1'b1;
                end
                else
                begin
                    counter_next = counter_reg + 1'b1;
                end
                state_next = ST_IDLE;
            end
            ST_MAC:
            begin
                if (step_reg == STEP_COEF_2)
                begin
                    state_next = ST_OUT;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            ST_OUT:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    load_out       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            step_reg       <= STEP_TOT_LO;
            acc_reg        <= '0;
            total_reg      <= '0;
            psum_reg       <= '0;
            counter_reg    <= '0;
            frame_done_reg <= 1'b0;
            live_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            step_reg       <= step_next;
            acc_reg        <= acc_next;
            total_reg      <= total_next;
            psum_reg       <= psum_next;
            counter_reg    <= counter_next;
            frame_done_reg <= frame_done_next;
            live_reg       <= live_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_issue)
        begin
            factor_reg <= factor_next;
        end
        if (state_reg == ST_MAC)
        begin
            wide_reg <= wide_next;
        end
        if (state_reg == ST_MAC && step_reg == STEP_COEF_0)
        begin
            s_reg <= wide_reg[S_W-1:0];
        end
        if (load_out)
        begin
            field_reg       <= live_reg ? field_sat : '0;
            field_ready_reg <= live_reg;
            sat_reg         <= live_reg && !in_range;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.field_value = field_reg;
    assign result.field_ready = field_ready_reg;
    assign result.saturated   = sat_reg;

    a_frame_from_close: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(frame_done_reg) |-> $past(state_reg) == ST_CLOSE)
        else $error("frame completed outside a cell close");

    a_result_from_out: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == ST_OUT)
        else $error("result raised outside the output state");

    a_mac_start: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MAC && step_reg == STEP_TOT_LO)
            |-> ($past(state_reg) == ST_IDLE && $past(frame_done_reg)))
        else $error("field evaluation started without a full frame");

endmodule

### sv/periodic_field_poisson_integrator.sv
// Periodic 1-D Poisson field integrator.
// item (pfpi_in_if, valid/ready): op 0 adds sample_value (Q16.16) to the
// current cell, end_of_cell closes the cell; op 1 reads the mean-removed
// field of cell_index (taken modulo NUM_CELLS). Only reads give a result.
// result (pfpi_out_if, valid/ready): field_value Q32.16 saturated, plus
// field_ready (a full frame of NUM_CELLS cells is held) and saturated.
// APB: one register, field_coefficient (signed Q16.16) at address 0.
// Processing: a plain sample is handled in the back end's IDLE state alone, an
// end-of-cell sample also passes CLOSE (prefix store write and total update).
// A read passes IDLE (RAM read), nine steps through the one 33x33 MAC unit
// and OUT (output load); a read before a full frame goes from IDLE to OUT.
// A four-entry queue decouples the input handshake from the back end, so
// samples are taken while a read is computed or a result waits.
// Reset clears the accumulators, cell count and frame flag; the prefix store
// is not cleared and is only read after a full frame has rewritten it.
// When the receiver stalls, the result register holds, the back end waits
// at its next result, and input stalls once the queue fills.
module periodic_field_poisson_integrator import pfpi_pkg::*; #(
    parameter int NUM_CELLS = NUM_CELLS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    pfpi_in_if.sink           item,
    pfpi_out_if.source        result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    logic signed [COEF_W-1:0] coef_reg;
    logic [APB_AW-3:0]        reg_idx;
    logic                     wr_en;
    queue_head_t              head;
    logic                     pop;

    // APB: zero-wait, written on the access phase
    assign pready  = 1'b1;
    assign reg_idx = paddr[APB_AW-1:2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg <= COEF_RESET;
        end
        else if (wr_en && reg_idx == REG_FIELD_COEF)
        begin
            coef_reg <= $signed(pwdata);
        end
    end

    assign prdata = (reg_idx == REG_FIELD_COEF) ? coef_reg : '0;

    // front end: takes transactions and queues them in order, tagged by kind
    pfpi_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .item  (item),
        .head  (head),
        .pop   (pop)
    );

    // back end: cell sums, prefix store, field evaluation, result register
    pfpi_back #(
        .NUM_CELLS (NUM_CELLS)
    ) u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (head),
        .pop    (pop),
        .coef   (coef_reg),
        .result (result)
    );

endmodule
